### rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

### rtl/sbe_pkg.sv
// shared types and constants for the segment box edge test
package sbe_pkg;
  localparam int CoordW = 16;
  localparam int FracW  = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int QW     = 2;
  localparam int AddrW  = 4;

  localparam logic [AddrW-1:0] RegLeft   = 4'd0;
  localparam logic [AddrW-1:0] RegRight  = 4'd4;
  localparam logic [AddrW-1:0] RegTop    = 4'd8;
  localparam logic [AddrW-1:0] RegBottom = 4'd12;

  typedef enum logic [2:0] {
    EdgeNone   = 3'd0,
    EdgeLeft   = 3'd1,
    EdgeTop    = 3'd2,
    EdgeRight  = 3'd3,
    EdgeBottom = 3'd4
  } edge_e;

  typedef struct packed {
    logic signed [CoordW-1:0] box_left;
    logic signed [CoordW-1:0] box_right;
    logic signed [CoordW-1:0] box_top;
    logic signed [CoordW-1:0] box_bottom;
  } box_t;

  // per-edge work handed from front to back
  typedef struct packed {
    logic              ok;
    logic [DiffW-1:0]  num;
    logic [DiffW-1:0]  den;
  } edge_job_t;

  typedef struct packed {
    edge_job_t [3:0] job;
  } item_t;

  typedef struct packed {
    logic              hit;
    logic [FracW:0]    fraction;
    logic [2:0]        hit_edge;
  } res_t;
endpackage

### rtl/sbe_if.sv
// valid/ready channel carrying a payload of type word_t
interface sbe_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

### rtl/sbe_front.sv
// front part: range tests on exact products, emits numerator/denominator per edge
module sbe_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sbe_pkg::box_t                   box_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [sbe_pkg::CoordW-1:0] start_x_i,
  input  logic signed [sbe_pkg::CoordW-1:0] start_y_i,
  input  logic signed [sbe_pkg::CoordW-1:0] delta_x_i,
  input  logic signed [sbe_pkg::CoordW-1:0] delta_y_i,
  input  logic [3:0]                      edge_mask_i,
  output logic                            q_valid_o,
  input  logic                            q_ready_i,
  output sbe_pkg::item_t                  q_item_o
);
  localparam int DW = sbe_pkg::DiffW;
  localparam int PW = sbe_pkg::ProdW;

  // stage 1 registers: signed differences, normalized to positive d
  logic                 s1_valid_q, s1_valid_d;
  logic [3:0]           s1_ok_q, s1_ok_d;
  logic signed [DW-1:0] s1_a_q [4], s1_a_d [4];
  logic signed [DW-1:0] s1_d_q [4], s1_d_d [4];
  logic signed [DW-1:0] s1_do_q [4], s1_do_d [4];
  logic signed [DW-1:0] s1_lo_q [4], s1_lo_d [4];
  logic signed [DW-1:0] s1_hi_q [4], s1_hi_d [4];

  // stage 2 registers
  logic           s2_valid_q;
  sbe_pkg::item_t s2_item_q, s2_item_d;

  logic s2_adv, s1_adv;
  assign s2_adv = !s2_valid_q || q_ready_i;
  assign s1_adv = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv;
  assign q_valid_o = s2_valid_q;
  assign q_item_o = s2_item_q;

  always_comb begin
    logic signed [DW-1:0] plane, pa, da, po, dd, e0, e1, a, lo, hi;
    s1_valid_d = in_valid_i;
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: begin
          plane = DW'(box_i.box_left); pa = DW'(start_x_i); da = DW'(delta_x_i);
          po = DW'(start_y_i); dd = DW'(delta_y_i);
          e0 = DW'(box_i.box_bottom); e1 = DW'(box_i.box_top);
        end
        1: begin
          plane = DW'(box_i.box_top); pa = DW'(start_y_i); da = DW'(delta_y_i);
          po = DW'(start_x_i); dd = DW'(delta_x_i);
          e0 = DW'(box_i.box_left); e1 = DW'(box_i.box_right);
        end
        2: begin
          plane = DW'(box_i.box_right); pa = DW'(start_x_i); da = DW'(delta_x_i);
          po = DW'(start_y_i); dd = DW'(delta_y_i);
          e0 = DW'(box_i.box_top); e1 = DW'(box_i.box_bottom);
        end
        default: begin
          plane = DW'(box_i.box_bottom); pa = DW'(start_y_i); da = DW'(delta_y_i);
          po = DW'(start_x_i); dd = DW'(delta_x_i);
          e0 = DW'(box_i.box_right); e1 = DW'(box_i.box_left);
        end
      endcase
      a  = plane - pa;
      lo = (e0 < e1) ? e0 : e1;
      hi = (e0 < e1) ? e1 : e0;
      if (da < 0) begin
        a = -a; da = -da; dd = -dd;
      end
      s1_ok_d[k] = edge_mask_i[k] && (da != 0) && (e0 != e1) && (a >= 0) && (a <= da);
      s1_a_d[k]  = a;
      s1_d_d[k]  = da;
      s1_do_d[k] = dd;
      s1_lo_d[k] = lo - po;
      s1_hi_d[k] = hi - po;
    end
  end

  always_comb begin
    logic signed [PW-1:0] cr, bl, bh;
    for (int k = 0; k < 4; k++) begin
      cr = PW'(s1_a_q[k]) * PW'(s1_do_q[k]);
      bl = PW'(s1_lo_q[k]) * PW'(s1_d_q[k]);
      bh = PW'(s1_hi_q[k]) * PW'(s1_d_q[k]);
      s2_item_d.job[k].ok  = s1_ok_q[k] && (cr >= bl) && (cr <= bh);
      s2_item_d.job[k].num = s1_a_q[k];
      s2_item_d.job[k].den = s1_d_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= s1_valid_d;
      if (s2_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_ok_q <= s1_ok_d;
      s1_a_q <= s1_a_d; s1_d_q <= s1_d_d; s1_do_q <= s1_do_d;
      s1_lo_q <= s1_lo_d; s1_hi_q <= s1_hi_d;
    end
    if (s2_adv) s2_item_q <= s2_item_d;
  end
endmodule

### rtl/sbe_fifo.sv
// short queue between front and back
module sbe_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  sbe_pkg::item_t wr_item_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output sbe_pkg::item_t rd_item_o
);
  localparam int D = 1 << sbe_pkg::QW;
  sbe_pkg::item_t mem_q [D];
  logic [sbe_pkg::QW-1:0] wp_q, rp_q;
  logic [sbe_pkg::QW:0]   cnt_q;
  logic wr, rd;
  assign wr_ready_o = cnt_q != (sbe_pkg::QW+1)'(D);
  assign rd_valid_o = cnt_q != '0;
  assign rd_item_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      if (wr && !rd) cnt_q <= cnt_q + 1'b1;
      else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_item_i;
  end
endmodule

### rtl/sbe_back.sv
// back part: pipelined restoring division per edge, then minimum select
module sbe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  sbe_pkg::item_t q_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sbe_pkg::res_t  out_res_o
);
  localparam int FW = sbe_pkg::FracW;
  localparam int DW = sbe_pkg::DiffW;
  localparam int NS = FW + 1;   // quotient bits, one per stage
  localparam int RW = DW + 1;

  logic             v_q [NS+1];
  logic [3:0]       ok_q [NS+1];
  logic [RW-1:0]    rem_q [NS+1][4];
  logic [DW-1:0]    den_q [NS+1][4];
  logic [FW:0]      quo_q [NS+1][4];
  sbe_pkg::res_t    res_q, res_d;
  logic             out_v_q;
  logic             adv;

  assign adv = !out_v_q || out_ready_i;
  assign q_ready_o = adv;
  assign out_valid_o = out_v_q;
  assign out_res_o = res_q;

  // stage 0 load: a <= d so a*2^FW/d fits in FW+1 bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NS; s++) v_q[s] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= q_valid_i;
      for (int s = 1; s <= NS; s++) v_q[s] <= v_q[s-1];
      out_v_q <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        ok_q[0][k]   <= q_item_i.job[k].ok;
        rem_q[0][k]  <= RW'(q_item_i.job[k].num);
        den_q[0][k]  <= q_item_i.job[k].den;
        quo_q[0][k]  <= '0;
      end
      for (int s = 1; s <= NS; s++) begin
        ok_q[s] <= ok_q[s-1];
        for (int k = 0; k < 4; k++) begin
          // first step compares a itself, later steps the doubled remainder
          logic [RW-1:0] r;
          r = (s == 1) ? rem_q[s-1][k] : (rem_q[s-1][k] << 1);
          den_q[s][k] <= den_q[s-1][k];
          if (r >= RW'(den_q[s-1][k])) begin
            rem_q[s][k] <= r - RW'(den_q[s-1][k]);
            quo_q[s][k] <= {quo_q[s-1][k][FW-1:0], 1'b1};
          end else begin
            rem_q[s][k] <= r;
            quo_q[s][k] <= {quo_q[s-1][k][FW-1:0], 1'b0};
          end
        end
      end
      res_q <= res_d;
    end
  end

  always_comb begin
    res_d = '0;
    for (int k = 0; k < 4; k++) begin
      if (ok_q[NS][k] && (!res_d.hit || quo_q[NS][k] < res_d.fraction)) begin
        res_d.hit = 1'b1;
        res_d.fraction = quo_q[NS][k];
        res_d.hit_edge = 3'(k + 1);
      end
    end
  end
endmodule

### rtl/segment_box_edge_hit_fraction.sv
// top level: box registers, front classifier, queue, divider back end
//  channel | dir | payload
//  in_ch   | in  | start_x, start_y, delta_x, delta_y, edge_mask
//  out_ch  | out | hit, fraction, hit_edge
//  apb     | in  | box_left/right/top/bottom at 0x0/0x4/0x8/0xc
// one word per cycle sustained unless out_ch stalls; via front stages 1 and 2, queue,
// load stage, 17 one-bit-per-stage divider stages and the select register
// back stalls only on out_ch ready; front runs on until the 4-entry queue fills
// reset clears all valid flags and box registers to zero
module segment_box_edge_hit_fraction (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [sbe_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sbe_if.sink         in_ch,
  sbe_if.source       out_ch
);
  sbe_pkg::box_t box_q;
  logic wr_en;
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else if (wr_en) begin
      case (paddr)
        sbe_pkg::RegLeft:   box_q.box_left   <= pwdata[sbe_pkg::CoordW-1:0];
        sbe_pkg::RegRight:  box_q.box_right  <= pwdata[sbe_pkg::CoordW-1:0];
        sbe_pkg::RegTop:    box_q.box_top    <= pwdata[sbe_pkg::CoordW-1:0];
        sbe_pkg::RegBottom: box_q.box_bottom <= pwdata[sbe_pkg::CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      sbe_pkg::RegLeft:   prdata = 32'(box_q.box_left);
      sbe_pkg::RegRight:  prdata = 32'(box_q.box_right);
      sbe_pkg::RegTop:    prdata = 32'(box_q.box_top);
      sbe_pkg::RegBottom: prdata = 32'(box_q.box_bottom);
      default:            prdata = '0;
    endcase
  end

  logic f_valid, f_ready, b_valid, b_ready;
  sbe_pkg::item_t f_item, b_item;
  sbe_pkg::res_t  res;

  sbe_front u_front (
    .clk_i, .rst_ni, .box_i(box_q),
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .start_x_i(in_ch.word.start_x), .start_y_i(in_ch.word.start_y),
    .delta_x_i(in_ch.word.delta_x), .delta_y_i(in_ch.word.delta_y),
    .edge_mask_i(in_ch.word.edge_mask),
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_item_o(f_item)
  );

  sbe_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_item_i(f_item),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_item_o(b_item)
  );

  sbe_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(b_valid), .q_ready_o(b_ready), .q_item_i(b_item),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_res_o(res)
  );

  assign out_ch.word.hit = res.hit;
  assign out_ch.word.fraction = res.fraction;
  assign out_ch.word.hit_edge = res.hit_edge;
endmodule

### rtl/sbe_checker.sv
// port-level checker for the segment box edge test, bound to the top level
`include "assert_macros.svh"
module sbe_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   hit,
  input logic [sbe_pkg::FracW:0] fraction,
  input logic [2:0]             hit_edge
);
  `ASSERT_IMPL(a_nohit_zero, clk_i, rst_ni, out_valid && !hit |-> fraction == '0 && hit_edge == sbe_pkg::EdgeNone, "miss word not zero")
  `ASSERT_IMPL(a_hit_edge, clk_i, rst_ni, out_valid && hit |-> hit_edge != sbe_pkg::EdgeNone && hit_edge <= sbe_pkg::EdgeBottom, "bad edge on hit")
  `ASSERT_IMPL(a_frac_max, clk_i, rst_ni, out_valid |-> fraction <= (sbe_pkg::FracW+1)'(1 << sbe_pkg::FracW), "fraction above one")
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(fraction), "stalled word changed")
  `ASSERT_IMPL(a_in_hold, clk_i, rst_ni, in_valid && !in_ready |=> in_valid, "input word dropped while stalled")
endmodule

bind segment_box_edge_hit_fraction sbe_checker u_sbe_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .hit(out_ch.word.hit), .fraction(out_ch.word.fraction),
  .hit_edge(out_ch.word.hit_edge)
);
